>>> hw/rtl/pfc_pkg.sv
// ---------------------------------------------------------------------------
// Pixel format converter package
// Shared types, register codes, reset values and conversion helpers.
// ---------------------------------------------------------------------------
package pfc_pkg;

    // Configuration register indexes
    typedef enum logic [2:0] {
        REG_SOURCE_FORMAT = 3'd0,
        REG_RED_OFFSET    = 3'd1,
        REG_RED_LENGTH    = 3'd2,
        REG_GREEN_OFFSET  = 3'd3,
        REG_GREEN_LENGTH  = 3'd4,
        REG_BLUE_OFFSET   = 3'd5,
        REG_BLUE_LENGTH   = 3'd6,
        REG_DEST_BYTES    = 3'd7
    } reg_index_t;

    // Source pixel layouts
    typedef enum logic [1:0] {
        FMT_RGBA32 = 2'd0,  // bytes B,G,R,A
        FMT_RGB888 = 2'd1,  // bytes B,G,R
        FMT_RGB565 = 2'd2,
        FMT_WORD   = 2'd3   // colour word 0xRRGGBBAA
    } src_format_t;

    // Reset values
    localparam logic [4:0] RedOffsetReset   = 5'd16;
    localparam logic [4:0] GreenOffsetReset = 5'd8;
    localparam logic [4:0] BlueOffsetReset  = 5'd0;
    localparam logic [4:0] LengthReset      = 5'd8;
    localparam logic [2:0] DestBytesReset   = 3'd4;

    typedef struct packed {
        src_format_t source_format;
        logic [4:0]  red_offset;
        logic [4:0]  red_length;
        logic [4:0]  green_offset;
        logic [4:0]  green_length;
        logic [4:0]  blue_offset;
        logic [4:0]  blue_length;
        logic [2:0]  dest_bytes;
    } cfg_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } rgb_t;

    // Rounded 5-bit to 8-bit expansion, (v*255 + 15) / 31
    localparam logic [7:0] EXPAND5 [32] = '{
        8'd0,   8'd8,   8'd16,  8'd25,  8'd33,  8'd41,  8'd49,  8'd58,
        8'd66,  8'd74,  8'd82,  8'd90,  8'd99,  8'd107, 8'd115, 8'd123,
        8'd132, 8'd140, 8'd148, 8'd156, 8'd165, 8'd173, 8'd181, 8'd189,
        8'd197, 8'd206, 8'd214, 8'd222, 8'd230, 8'd239, 8'd247, 8'd255
    };

    // Rounded 6-bit to 8-bit expansion, (v*255 + 31) / 63
    // = 4v + floor((3v + 31) / 63); the second term steps at 11, 32 and 53
    function automatic logic [7:0] expand6(input logic [5:0] v);
        logic [1:0] corr;
        begin
            if (v >= 6'd53)
                corr = 2'd3;
            else if (v >= 6'd32)
                corr = 2'd2;
            else if (v >= 6'd11)
                corr = 2'd1;
            else
                corr = 2'd0;
            expand6 = {v, 2'b00} + {6'd0, corr};
        end
    endfunction

    // Re-quantise an 8-bit channel to len bits and move it to bit off
    function automatic logic [31:0] place_channel(
        input logic [7:0] v8,
        input logic [4:0] len,
        input logic [4:0] off
    );
        logic [31:0] q;
        begin
            if (len == 5'd0)
                q = '0;
            else if (len >= 5'd8)
                q = {24'd0, v8} << (len - 5'd8);
            else
                q = {24'd0, v8 >> (4'd8 - {1'b0, len[2:0]})};
            place_channel = q << off;
        end
    endfunction

endpackage

>>> hw/rtl/pfc_if.sv
// ---------------------------------------------------------------------------
// Pixel format converter stream interfaces
// Valid/ready channels for raw source pixels and converted pixels.
// ---------------------------------------------------------------------------
interface pfc_raw_if;
    logic        valid;
    logic        ready;
    logic [31:0] source_pixel;

    modport source (output valid, output source_pixel, input ready);
    modport sink   (input valid, input source_pixel, output ready);
endinterface

interface pfc_conv_if;
    logic        valid;
    logic        ready;
    logic [31:0] packed_pixel;
    logic [2:0]  pixel_bytes;

    modport source (output valid, output packed_pixel, output pixel_bytes, input ready);
    modport sink   (input valid, input packed_pixel, input pixel_bytes, output ready);
endinterface

>>> hw/rtl/pixel_format_converter_unit.sv
// ---------------------------------------------------------------------------
// Pixel format converter
// A beat accepted into the input register is presented from the result register.
// Throughput: one pixel per cycle; input register, then decode/pack logic,
// then result register, each stage advancing whenever the next can take it.
// Reset: stage valids clear, configuration returns to its default values.
// ---------------------------------------------------------------------------
module pixel_format_converter_unit (
    input  logic              clk,
    input  logic              rst_n,
    pfc_raw_if.sink           raw_chan,
    pfc_conv_if.source        conv_chan,
    input  logic              cfg_we,
    input  logic [2:0]        cfg_index,
    input  logic [4:0]        cfg_data
);

    pfc_pkg::cfg_t   cfg_reg;
    logic            s1_valid_reg;
    logic [31:0]     s1_pixel_reg;
    logic            s2_valid_reg;
    logic [31:0]     s2_word_reg;
    logic [2:0]      s2_bytes_reg;

    logic            s1_ready;
    logic            s2_ready;
    pfc_pkg::rgb_t   rgb;
    logic [31:0]     word_full;
    logic [31:0]     word_next;
    logic [2:0]      bytes_next;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.source_format <= pfc_pkg::FMT_RGBA32;
            cfg_reg.red_offset    <= pfc_pkg::RedOffsetReset;
            cfg_reg.red_length    <= pfc_pkg::LengthReset;
            cfg_reg.green_offset  <= pfc_pkg::GreenOffsetReset;
            cfg_reg.green_length  <= pfc_pkg::LengthReset;
            cfg_reg.blue_offset   <= pfc_pkg::BlueOffsetReset;
            cfg_reg.blue_length   <= pfc_pkg::LengthReset;
            cfg_reg.dest_bytes    <= pfc_pkg::DestBytesReset;
        end
        else if (cfg_we)
        begin
            case (pfc_pkg::reg_index_t'(cfg_index))
                pfc_pkg::REG_SOURCE_FORMAT:
                    cfg_reg.source_format <= pfc_pkg::src_format_t'(cfg_data[1:0]);
                pfc_pkg::REG_RED_OFFSET:   cfg_reg.red_offset   <= cfg_data;
                pfc_pkg::REG_RED_LENGTH:   cfg_reg.red_length   <= cfg_data;
                pfc_pkg::REG_GREEN_OFFSET: cfg_reg.green_offset <= cfg_data;
                pfc_pkg::REG_GREEN_LENGTH: cfg_reg.green_length <= cfg_data;
                pfc_pkg::REG_BLUE_OFFSET:  cfg_reg.blue_offset  <= cfg_data;
                pfc_pkg::REG_BLUE_LENGTH:  cfg_reg.blue_length  <= cfg_data;
                pfc_pkg::REG_DEST_BYTES:   cfg_reg.dest_bytes   <= cfg_data[2:0];
                default: ;
            endcase
        end
    end

    // Stage handshakes
    assign s2_ready       = !s2_valid_reg || conv_chan.ready;
    assign s1_ready       = !s1_valid_reg || s2_ready;
    assign raw_chan.ready = s1_ready;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (s1_ready)
            s1_valid_reg <= raw_chan.valid;
    end

    always_ff @(posedge clk)
    begin
        if (s1_ready && raw_chan.valid)
            s1_pixel_reg <= raw_chan.source_pixel;
    end

    // Decode
    pfc_decode u_decode (
        .source_pixel  (s1_pixel_reg),
        .source_format (cfg_reg.source_format),
        .rgb           (rgb)
    );

    // Pack channels and truncate to the destination size
    assign word_full = pfc_pkg::place_channel(rgb.red, cfg_reg.red_length,
                                              cfg_reg.red_offset)
                     | pfc_pkg::place_channel(rgb.green, cfg_reg.green_length,
                                              cfg_reg.green_offset)
                     | pfc_pkg::place_channel(rgb.blue, cfg_reg.blue_length,
                                              cfg_reg.blue_offset);

    always_comb
    begin
        case (cfg_reg.dest_bytes)
            3'd2:
            begin
                bytes_next = 3'd2;
                word_next  = {16'd0, word_full[15:0]};
            end
            3'd3:
            begin
                bytes_next = 3'd3;
                word_next  = {8'd0, word_full[23:0]};
            end
            default:
            begin
                bytes_next = 3'd4;
                word_next  = word_full;
            end
        endcase
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else if (s2_ready)
            s2_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (s2_ready && s1_valid_reg)
        begin
            s2_word_reg  <= word_next;
            s2_bytes_reg <= bytes_next;
        end
    end

    assign conv_chan.valid        = s2_valid_reg;
    assign conv_chan.packed_pixel = s2_word_reg;
    assign conv_chan.pixel_bytes  = s2_bytes_reg;

endmodule

>>> hw/rtl/pfc_decode.sv
// ---------------------------------------------------------------------------
// Source pixel decoder
// Splits a raw source pixel into 8-bit red, green and blue by layout.
// ---------------------------------------------------------------------------
module pfc_decode (
    input  logic [31:0]                source_pixel,
    input  pfc_pkg::src_format_t       source_format,
    output pfc_pkg::rgb_t              rgb
);

    // Byte or field pick per layout; RGB565 goes through EXPAND5 and expand6
    always_comb
    begin
        case (source_format)
            pfc_pkg::FMT_RGB565:
            begin
                rgb.red   = pfc_pkg::EXPAND5[source_pixel[15:11]];
                rgb.green = pfc_pkg::expand6(source_pixel[10:5]);
                rgb.blue  = pfc_pkg::EXPAND5[source_pixel[4:0]];
            end
            pfc_pkg::FMT_WORD:
            begin
                rgb.red   = source_pixel[31:24];
                rgb.green = source_pixel[23:16];
                rgb.blue  = source_pixel[15:8];
            end
            pfc_pkg::FMT_RGBA32, pfc_pkg::FMT_RGB888:
            begin
                rgb.red   = source_pixel[23:16];
                rgb.green = source_pixel[15:8];
                rgb.blue  = source_pixel[7:0];
            end
            default:
            begin
                rgb.red   = source_pixel[23:16];
                rgb.green = source_pixel[15:8];
                rgb.blue  = source_pixel[7:0];
            end
        endcase
    end

endmodule

>>> dv/pfc_pixel_checker.sv
// ---------------------------------------------------------------------------
// Pixel format converter checker
// Watches both pixel channels and the register write port, works out the
// converted pixel for every accepted source beat and compares each converted
// beat, field by field, with the oldest outstanding prediction.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module pfc_pixel_checker (
    input  logic        clk,
    input  logic        rst_n,
    pfc_raw_if          raw_chan,
    pfc_conv_if         conv_chan,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [4:0]  cfg_data,
    output int unsigned fail_count,
    output int unsigned pixels_in_flight
);

    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  nbytes;
    } conv_pixel_t;

    // Shadow copy of the layout registers
    pfc_pkg::src_format_t fmt;
    logic [4:0]  red_off;
    logic [4:0]  red_len;
    logic [4:0]  grn_off;
    logic [4:0]  grn_len;
    logic [4:0]  blu_off;
    logic [4:0]  blu_len;
    logic [2:0]  dst_bytes;

    conv_pixel_t expected_pixels[$];

    // Rounded widening of a narrow field to 8 bits
    function automatic logic [7:0] scale_up(int unsigned v, int unsigned maxv);
        return 8'((v * 255 + maxv / 2) / maxv);
    endfunction

    // Re-quantise to len bits, move to bit off, drop anything past bit 31
    function automatic logic [31:0] pack_channel(logic [7:0] v8, logic [4:0] len,
                                                 logic [4:0] off);
        logic [63:0] q;
        if (len == 5'd0)
            q = '0;
        else if (len >= 5'd8)
            q = {56'd0, v8} << (int'(len) - 8);
        else
            q = {56'd0, v8 >> (8 - int'(len))};
        q = q & 64'hFFFF_FFFF;
        q = q << off;
        return q[31:0];
    endfunction

    function automatic conv_pixel_t convert_pixel(logic [31:0] px);
        conv_pixel_t res;
        logic [7:0]  r;
        logic [7:0]  g;
        logic [7:0]  b;
        case (fmt)
            pfc_pkg::FMT_RGB565:
            begin
                r = scale_up(int'(px[15:11]), 31);
                g = scale_up(int'(px[10:5]), 63);
                b = scale_up(int'(px[4:0]), 31);
            end
            pfc_pkg::FMT_WORD:
            begin
                r = px[31:24];
                g = px[23:16];
                b = px[15:8];
            end
            default:
            begin
                // RGBA32 and RGB888 share the byte order, top byte ignored
                r = px[23:16];
                g = px[15:8];
                b = px[7:0];
            end
        endcase
        res.word = pack_channel(r, red_len, red_off)
                 | pack_channel(g, grn_len, grn_off)
                 | pack_channel(b, blu_len, blu_off);
        // Anything other than 2 or 3 bytes behaves as a full word
        case (dst_bytes)
            3'd2:
            begin
                res.nbytes = 3'd2;
                res.word   = res.word & 32'h0000_FFFF;
            end
            3'd3:
            begin
                res.nbytes = 3'd3;
                res.word   = res.word & 32'h00FF_FFFF;
            end
            default:
            begin
                res.nbytes = 3'd4;
            end
        endcase
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        conv_pixel_t exp_px;
        if (!rst_n)
        begin
            fmt       = pfc_pkg::FMT_RGBA32;
            red_off   = pfc_pkg::RedOffsetReset;
            red_len   = pfc_pkg::LengthReset;
            grn_off   = pfc_pkg::GreenOffsetReset;
            grn_len   = pfc_pkg::LengthReset;
            blu_off   = pfc_pkg::BlueOffsetReset;
            blu_len   = pfc_pkg::LengthReset;
            dst_bytes = pfc_pkg::DestBytesReset;
            expected_pixels.delete();
            fail_count = 0;
            pixels_in_flight <= 0;
        end
        else
        begin
            // Converted beat against the oldest prediction
            if (conv_chan.valid && conv_chan.ready)
            begin
                if (expected_pixels.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: converted beat %08h with nothing outstanding",
                             $time, conv_chan.packed_pixel);
                end
                else
                begin
                    exp_px = expected_pixels.pop_front();
                    if (conv_chan.packed_pixel !== exp_px.word)
                    begin
                        fail_count++;
                        $display("%0t: packed_pixel expected %08h, got %08h",
                                 $time, exp_px.word, conv_chan.packed_pixel);
                    end
                    if (conv_chan.pixel_bytes !== exp_px.nbytes)
                    begin
                        fail_count++;
                        $display("%0t: pixel_bytes expected %0d, got %0d",
                                 $time, exp_px.nbytes, conv_chan.pixel_bytes);
                    end
                end
            end

            // Source beat: predict with the layout in force now
            if (raw_chan.valid && raw_chan.ready)
                expected_pixels.push_back(convert_pixel(raw_chan.source_pixel));

            // Register writes must land only while the block is idle; this checker does not enforce it
            if (cfg_we)
            begin
                case (pfc_pkg::reg_index_t'(cfg_index))
                    pfc_pkg::REG_SOURCE_FORMAT:
                        fmt = pfc_pkg::src_format_t'(cfg_data[1:0]);
                    pfc_pkg::REG_RED_OFFSET:   red_off   = cfg_data;
                    pfc_pkg::REG_RED_LENGTH:   red_len   = cfg_data;
                    pfc_pkg::REG_GREEN_OFFSET: grn_off   = cfg_data;
                    pfc_pkg::REG_GREEN_LENGTH: grn_len   = cfg_data;
                    pfc_pkg::REG_BLUE_OFFSET:  blu_off   = cfg_data;
                    pfc_pkg::REG_BLUE_LENGTH:  blu_len   = cfg_data;
                    pfc_pkg::REG_DEST_BYTES:   dst_bytes = cfg_data[2:0];
                    default: ;
                endcase
            end

            pixels_in_flight <= expected_pixels.size();
        end
    end

endmodule

>>> dv/tb_pixel_format_converter_unit.sv
// ---------------------------------------------------------------------------
// Pixel format converter testbench
// Drives source pixels through a series of destination layouts, directed
// corner cases first and then random layouts and pixels, with random gaps
// and back-pressure; the checker beside the block does the comparison.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_pixel_format_converter_unit;

    localparam int unsigned CycleLimit     = 200000;
    localparam int unsigned RandomPhases   = 20;
    localparam int unsigned PixelsPerPhase = 50;
    localparam int unsigned HoldCycles     = 150;
    localparam int unsigned SettleCycles   = 4;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [4:0]  cfg_data;
    int unsigned fail_count;
    int unsigned pixels_in_flight;
    int unsigned cycle_count = 0;
    bit          steady;
    bit          hold_toggle;

    pfc_raw_if  raw_chan ();
    pfc_conv_if conv_chan ();

    pixel_format_converter_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .raw_chan  (raw_chan),
        .conv_chan (conv_chan),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    pfc_pixel_checker i_checker (
        .clk              (clk),
        .rst_n            (rst_n),
        .raw_chan         (raw_chan),
        .conv_chan        (conv_chan),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .fail_count       (fail_count),
        .pixels_in_flight (pixels_in_flight)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CycleLimit)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // Receiver: random stalls, plus one long hold-off on request
    initial
    begin : receiver
        int unsigned stall_left;
        bit          seen_toggle;
        stall_left  = 0;
        seen_toggle = 1'b0;
        conv_chan.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_toggle != seen_toggle)
            begin
                seen_toggle = hold_toggle;
                stall_left  = HoldCycles;
            end
            if (stall_left != 0)
            begin
                stall_left--;
                conv_chan.ready <= 1'b0;
            end
            else if (steady)
                conv_chan.ready <= 1'b1;
            else
                conv_chan.ready <= ($urandom_range(99) >= 8);
        end
    end

    // One source beat, with an occasional gap in front of it
    task automatic send_pixel(logic [31:0] px);
        int unsigned gap;
        if (!steady && $urandom_range(99) < 3)
        begin
            raw_chan.valid <= 1'b0;
            gap = $urandom_range(1, 5);
            repeat (gap) @(posedge clk);
        end
        raw_chan.valid        <= 1'b1;
        raw_chan.source_pixel <= px;
        do
            @(posedge clk);
        while (raw_chan.ready !== 1'b1);
    endtask

    // Stop sending and wait until every converted beat has come back
    task automatic drain();
        raw_chan.valid <= 1'b0;
        @(posedge clk);
        while (pixels_in_flight != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(pfc_pkg::reg_index_t idx, logic [4:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Full destination layout, written once the block is idle
    task automatic load_layout(pfc_pkg::src_format_t f,
                               logic [4:0] roff, logic [4:0] rlen,
                               logic [4:0] goff, logic [4:0] glen,
                               logic [4:0] boff, logic [4:0] blen,
                               logic [2:0] nbytes);
        drain();
        write_reg(pfc_pkg::REG_SOURCE_FORMAT, 5'(f));
        write_reg(pfc_pkg::REG_RED_OFFSET, roff);
        write_reg(pfc_pkg::REG_RED_LENGTH, rlen);
        write_reg(pfc_pkg::REG_GREEN_OFFSET, goff);
        write_reg(pfc_pkg::REG_GREEN_LENGTH, glen);
        write_reg(pfc_pkg::REG_BLUE_OFFSET, boff);
        write_reg(pfc_pkg::REG_BLUE_LENGTH, blen);
        write_reg(pfc_pkg::REG_DEST_BYTES, 5'(nbytes));
    endtask

    initial
    begin : stimulus
        int unsigned phase;
        int unsigned n;
        rst_n                 <= 1'b0;
        cfg_we                <= 1'b0;
        cfg_index             <= pfc_pkg::REG_SOURCE_FORMAT;
        cfg_data              <= '0;
        raw_chan.valid        <= 1'b0;
        raw_chan.source_pixel <= '0;
        steady                <= 1'b0;
        hold_toggle           <= 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Reset layout: RGBA32 in, xRGB8888 out, alpha byte ignored
        send_pixel(32'h0000_0000);
        send_pixel(32'hFFFF_FFFF);
        send_pixel(32'h1234_5678);

        // RGB565 round trip, field extremes, upper half ignored
        load_layout(pfc_pkg::FMT_RGB565, 5'd11, 5'd5, 5'd5, 5'd6, 5'd0, 5'd5, 3'd2);
        send_pixel(32'h0000_0000);
        send_pixel(32'h0000_FFFF);
        send_pixel(32'h0000_F800);
        send_pixel(32'h0000_07E0);
        send_pixel(32'h0000_001F);
        send_pixel(32'hABCD_0841);

        // Colour word; zero length, short length, length past 16,
        // offsets pushing bits off the top, three-byte output
        load_layout(pfc_pkg::FMT_WORD, 5'd31, 5'd0, 5'd30, 5'd3, 5'd20, 5'd20, 3'd3);
        send_pixel(32'hFFFF_FFFF);
        send_pixel(32'h8080_8080);
        send_pixel(32'h0102_0304);

        // RGB888 with overlapping fields, longest length, zero byte count
        load_layout(pfc_pkg::FMT_RGB888, 5'd0, 5'd31, 5'd0, 5'd16, 5'd31, 5'd1, 3'd0);
        send_pixel(32'hFFFF_FFFF);
        send_pixel(32'h00A5_C3E7);
        send_pixel(32'h7F00_0001);

        // Odd byte counts that fall back to a full word
        load_layout(pfc_pkg::FMT_RGB565, 5'd1, 5'd8, 5'd9, 5'd7, 5'd17, 5'd9, 3'd7);
        send_pixel(32'h0000_A5A5);
        send_pixel(32'hFFFF_5A5A);
        load_layout(pfc_pkg::FMT_RGBA32, 5'd24, 5'd8, 5'd16, 5'd8, 5'd8, 5'd8, 3'd1);
        send_pixel(32'hDEAD_BEEF);
        send_pixel(32'h0F0F_0F0F);

        // Random layouts, each followed by a run of random pixels
        for (phase = 0; phase < RandomPhases; phase++)
        begin
            case ($urandom_range(2))
                0:
                    load_layout(pfc_pkg::src_format_t'($urandom_range(3)), 5'd16, 5'd8,
                                5'd8, 5'd8, 5'd0, 5'd8, 3'($urandom_range(2, 4)));
                1:
                    load_layout(pfc_pkg::src_format_t'($urandom_range(3)), 5'd11, 5'd5,
                                5'd5, 5'd6, 5'd0, 5'd5, 3'd2);
                default:
                    load_layout(pfc_pkg::src_format_t'($urandom_range(3)),
                                5'($urandom_range(31)), 5'($urandom_range(31)),
                                5'($urandom_range(31)), 5'($urandom_range(31)),
                                5'($urandom_range(31)), 5'($urandom_range(31)),
                                3'($urandom_range(7)));
            endcase
            // A stretch with no gaps and no stalls on either side
            steady <= (phase == 3 || phase == 4);
            // Long receiver hold-off while the sender keeps offering
            if (phase == 7)
                hold_toggle <= ~hold_toggle;
            for (n = 0; n < PixelsPerPhase; n++)
                send_pixel($urandom());
        end

        drain();
        repeat (SettleCycles) @(posedge clk);
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
